>>> sv/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressed record table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    // Table geometry; slot arithmetic wraps on SLOT_W bits, so the size is
    // a power of two.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int MAX_MATCHES = 63;
    localparam int EMIT_W      = $clog2(MAX_MATCHES + 1);

    // Port field widths
    localparam int MODE_W  = 2;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ID_W    = 31;
    localparam int GRADE_W = 31;
    localparam int STAT_W  = 3;
    localparam int OSLOT_W = 10;
    localparam int OCNT_W  = 11;

    // Home slot hash: ((day*5 + month*4 + year/48) / 7).
    // year/48 = (year >> 4) / 3, and x/3 = (x * 683) >> 11 for x < 1024.
    // s/7 = (s * 293) >> 11 for s < 685 (s never exceeds 556).
    localparam int YSH_W    = YEAR_W - 4;
    localparam int Q48_W    = 9;
    localparam int DM_W     = 8;
    localparam int SUM_W    = 10;
    localparam int HOME_W   = 7;
    localparam int RECIP3   = 683;
    localparam int RECIP7   = 293;
    localparam int RECIP_SH = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_IGNORE = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_MATCH    = 3'd2,
        STAT_END      = 3'd3,
        STAT_REMOVED  = 3'd4
    } t_status;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_key;

    typedef struct packed {
        logic               used;
        t_key               key;
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [OSLOT_W-1:0] slot;
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
        logic [OCNT_W-1:0]  count;
        logic               last;
    } t_rsp;

endpackage

`default_nettype wire

>>> sv/oaht_req_if.sv
// ----------------------------------------------------------------------------
// oaht_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface oaht_req_if import oaht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [DAY_W-1:0]   birth_day;
    logic [MONTH_W-1:0] birth_month;
    logic [YEAR_W-1:0]  birth_year;
    logic [ID_W-1:0]    student_id;
    logic [GRADE_W-1:0] grade;

    modport source (
        output valid, mode, birth_day, birth_month, birth_year, student_id, grade,
        input  ready
    );
    modport sink (
        input  valid, mode, birth_day, birth_month, birth_year, student_id, grade,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/oaht_rsp_if.sv
// ----------------------------------------------------------------------------
// oaht_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface oaht_rsp_if import oaht_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [OSLOT_W-1:0] slot;
    logic [ID_W-1:0]    found_id;
    logic [GRADE_W-1:0] found_grade;
    logic [OCNT_W-1:0]  match_count;
    logic               last;

    modport source (
        output valid, status, slot, found_id, found_grade, match_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot, found_id, found_grade, match_count, last,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/oaht_home.sv
// ----------------------------------------------------------------------------
// oaht_home
// Two-stage home slot calculator; the output is the stage 2 register.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_home import oaht_pkg::*; (
    input  wire              i_clk,
    input  t_key             i_key,
    output logic [SLOT_W-1:0] o_home
);

    logic [YSH_W-1:0]              ysh;
    logic [YSH_W+RECIP_SH-1:0]     prod3;
    logic [Q48_W-1:0]              n_q48;
    logic [DM_W-1:0]               n_dm;
    logic [Q48_W-1:0]              r_q48;
    logic [DM_W-1:0]               r_dm;
    logic [SUM_W-1:0]              sum;
    logic [SUM_W+RECIP_SH-1:0]     prod7;
    logic [HOME_W-1:0]             n_home;
    logic [HOME_W-1:0]             r_home;

    // Stage 1: year/48 and the weighted day/month sum
    always_comb begin
        ysh   = i_key.year[YEAR_W-1:4];
        prod3 = (YSH_W+RECIP_SH)'(ysh) * (YSH_W+RECIP_SH)'(RECIP3);
        n_q48 = Q48_W'(prod3 >> RECIP_SH);
        n_dm  = DM_W'(i_key.day) * DM_W'(5) + DM_W'(i_key.month) * DM_W'(4);
    end

    // Stage 2: divide by 7
    always_comb begin
        sum    = SUM_W'(r_q48) + SUM_W'(r_dm);
        prod7  = (SUM_W+RECIP_SH)'(sum) * (SUM_W+RECIP_SH)'(RECIP7);
        n_home = HOME_W'(prod7 >> RECIP_SH);
    end

    always_ff @(posedge i_clk) begin
        r_q48  <= n_q48;
        r_dm   <= n_dm;
        r_home <= n_home;
    end

    // Reduce modulo the (power of two) table size
    assign o_home = SLOT_W'(r_home);

endmodule

`default_nettype wire

>>> sv/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressed record table keyed by birth date, with insert, find and
// remove requests walking a linear or quadratic probe run in slot memory.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Transaction
//  i_req     in   valid/ready          one request (insert, find, remove)
//  o_rsp     out  valid/ready          one result; last marks the final one
//  i_cfg_*   in   write enable only    probe_mode register write
//
//  A request passes HASH1, HASH2, ADDR, EVAL over 1 to 1024 probed slots and
//  DONE; a full table answers an insert from ADDR. The loop, paced by the
//  memory read, is one slot read and one evaluation per cycle unless a match
//  result waits on a stalled output. After reset a clearing pass empties the
//  1024 slots, one per cycle; no request is taken during it. A stalled
//  result holds the probe walk only when a further result must be issued.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressing_hash_table import oaht_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    oaht_req_if.sink    i_req,
    oaht_rsp_if.source  o_rsp
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_HASH1 = 7'b0000100,
        ST_HASH2 = 7'b0001000,
        ST_ADDR  = 7'b0010000,
        ST_EVAL  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  OCC_MAX   = CNT_W'(TABLE_SLOTS);
    localparam logic [EMIT_W-1:0] EMIT_MAX  = EMIT_W'(MAX_MATCHES);

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_clr, n_clr;
    t_mode                r_mode, n_mode;
    t_key                 r_key, n_key;
    logic [ID_W-1:0]      r_id, n_id;
    logic [GRADE_W-1:0]   r_grade, n_grade;
    logic [SLOT_W-1:0]    r_pos, n_pos;
    logic [SLOT_W-1:0]    r_qi, n_qi;
    logic [SLOT_W-1:0]    r_qsq, n_qsq;
    logic [CNT_W-1:0]     r_probes, n_probes;
    logic [CNT_W-1:0]     r_hits, n_hits;
    logic [EMIT_W-1:0]    r_emitted, n_emitted;
    t_status              r_fin, n_fin;
    logic [SLOT_W-1:0]    r_fin_slot, n_fin_slot;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic                 r_probe_mode;
    logic                 r_ov, n_ov;
    t_rsp                 r_out, n_out;

    // Slot memory
    t_entry               mem [TABLE_SLOTS];
    t_entry               r_rd;
    logic                 mem_we, mem_re;
    logic [SLOT_W-1:0]    wr_addr, rd_addr;
    t_entry               wr_data;

    logic [SLOT_W-1:0]    home;
    logic                 accept, can_emit, hit, need_emit, probing;
    logic [SLOT_W-1:0]    next_pos;
    logic [CNT_W-1:0]     probes_inc;

    oaht_home u_home (
        .i_clk  (i_clk),
        .i_key  (r_key),
        .o_home (home)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign can_emit    = !r_ov || o_rsp.ready;

    // Probe evaluation on the registered memory word
    always_comb begin
        probing    = (r_mode == MODE_FIND) || (r_mode == MODE_REMOVE);
        hit        = probing && r_rd.used && (r_rd.key == r_key);
        need_emit  = hit && (r_mode == MODE_FIND) && (r_emitted < EMIT_MAX);
        probes_inc = r_probes + CNT_W'(1);
        if (hit || !r_probe_mode) begin
            next_pos = r_pos + SLOT_W'(1);
        end else begin
            next_pos = r_pos + r_qsq;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_mode     = r_mode;
        n_key      = r_key;
        n_id       = r_id;
        n_grade    = r_grade;
        n_pos      = r_pos;
        n_qi       = r_qi;
        n_qsq      = r_qsq;
        n_probes   = r_probes;
        n_hits     = r_hits;
        n_emitted  = r_emitted;
        n_fin      = r_fin;
        n_fin_slot = r_fin_slot;
        n_occ      = r_occ;
        n_ov       = r_ov && !o_rsp.ready;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_addr    = r_pos;
        rd_addr    = r_pos;
        wr_data    = r_rd;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                wr_addr      = r_clr;
                wr_data      = '0;
                n_clr        = r_clr + SLOT_W'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_mode  = t_mode'(i_req.mode);
                    n_key   = '{day: i_req.birth_day, month: i_req.birth_month,
                                year: i_req.birth_year};
                    n_id    = i_req.student_id;
                    n_grade = i_req.grade;
                    if (t_mode'(i_req.mode) != MODE_IGNORE) begin
                        n_state = ST_HASH1;
                    end
                end
            end
            ST_HASH1: begin
                n_state = ST_HASH2;
            end
            ST_HASH2: begin
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                n_pos     = home;
                n_qi      = '0;
                n_qsq     = '0;
                n_probes  = '0;
                n_hits    = '0;
                n_emitted = '0;
                if (r_mode == MODE_INSERT && r_occ >= OCC_MAX) begin
                    n_fin   = STAT_FULL;
                    n_state = ST_DONE;
                end else begin
                    mem_re  = 1'b1;
                    rd_addr = home;
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!(need_emit && !can_emit)) begin
                    if (!r_rd.used) begin
                        if (r_mode == MODE_INSERT) begin
                            mem_we     = 1'b1;
                            wr_data    = '{used: 1'b1, key: r_key, id: r_id,
                                           grade: r_grade};
                            n_occ      = r_occ + CNT_W'(1);
                            n_fin      = STAT_INSERTED;
                            n_fin_slot = r_pos;
                        end else begin
                            n_fin = (r_mode == MODE_FIND) ? STAT_END : STAT_REMOVED;
                        end
                        n_state = ST_DONE;
                    end else begin
                        if (hit) begin
                            n_hits = r_hits + CNT_W'(1);
                            if (r_mode == MODE_REMOVE) begin
                                // drop the record, no tombstone
                                mem_we       = 1'b1;
                                wr_data.used = 1'b0;
                                if (r_occ != '0) begin
                                    n_occ = r_occ - CNT_W'(1);
                                end
                            end
                        end else if (r_probe_mode) begin
                            n_qi  = r_qi + SLOT_W'(1);
                            n_qsq = r_qsq + {r_qi[SLOT_W-2:0], 1'b1};
                        end
                        if (need_emit) begin
                            n_emitted = r_emitted + EMIT_W'(1);
                            n_ov      = 1'b1;
                            n_out     = '{status: STAT_MATCH,
                                          slot:   OSLOT_W'(r_pos),
                                          id:     r_rd.id,
                                          grade:  r_rd.grade,
                                          count:  OCNT_W'(r_hits + CNT_W'(1)),
                                          last:   1'b0};
                        end
                        n_pos    = next_pos;
                        n_probes = probes_inc;
                        if (probes_inc == OCC_MAX) begin
                            priority case (r_mode)
                                MODE_INSERT: n_fin = STAT_FULL;
                                MODE_FIND:   n_fin = STAT_END;
                                default:     n_fin = STAT_REMOVED;
                            endcase
                            n_state = ST_DONE;
                        end else begin
                            mem_re  = 1'b1;
                            rd_addr = next_pos;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (can_emit) begin
                    n_ov    = 1'b1;
                    n_out   = '{status: r_fin,
                                slot:   (r_fin == STAT_INSERTED) ?
                                        OSLOT_W'(r_fin_slot) : '0,
                                id:     '0,
                                grade:  '0,
                                count:  (r_fin == STAT_END || r_fin == STAT_REMOVED) ?
                                        OCNT_W'(r_hits) : '0,
                                last:   1'b1};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_occ        <= '0;
            r_ov         <= 1'b0;
            r_probe_mode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_occ   <= n_occ;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_probe_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_id       <= n_id;
        r_grade    <= n_grade;
        r_pos      <= n_pos;
        r_qi       <= n_qi;
        r_qsq      <= n_qsq;
        r_probes   <= n_probes;
        r_hits     <= n_hits;
        r_emitted  <= n_emitted;
        r_fin      <= n_fin;
        r_fin_slot <= n_fin_slot;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.slot        = r_out.slot;
    assign o_rsp.found_id    = r_out.id;
    assign o_rsp.found_grade = r_out.grade;
    assign o_rsp.match_count = r_out.count;
    assign o_rsp.last        = r_out.last;

    // Occupancy never passes the table size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_MAX)
        else $error("occupancy above table size");

    // A write back never lands on the slot being read in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (wr_addr != rd_addr))
        else $error("slot read and write collide");

    // Emitted matches stay within the per-request limit
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> (r_emitted <= EMIT_MAX))
        else $error("too many match results");

    // A probe run never goes past the table size
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> (r_probes < OCC_MAX))
        else $error("probe run too long");

    // A new result is loaded only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rsp.ready) |=> ($stable(r_out) && r_ov))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> verif/open_addressing_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Self-checking bench for the birth-date record table. Requests are queued
// by the stimulus process, sent by a clocked driver with random gaps, and
// applied to a table model at acceptance. A clocked monitor pops the oldest
// expected result for each result transaction. The run covers both probe
// modes, duplicate and colliding keys, holes left by removal and searches
// with more matches than are reported.
// ----------------------------------------------------------------------------

module open_addressing_hash_table_tb;
    import oaht_pkg::*;

    localparam int DRAIN_CYCLES = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int KEY_POOL     = 12;
    localparam int FILL_KEYS    = 4;
    localparam int PHASE_ITEMS  = 60;
    localparam int DUP_ITEMS    = 66;
    localparam int FILL_ITEMS   = 72;

    typedef struct packed {
        t_mode              mode;
        t_key               key;
        logic [ID_W-1:0]    id;
        logic [GRADE_W-1:0] grade;
    } t_request;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    oaht_req_if req_if ();
    oaht_rsp_if rsp_if ();

    open_addressing_hash_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Table model
    bit                 slot_used  [TABLE_SLOTS];
    t_key               slot_key   [TABLE_SLOTS];
    logic [ID_W-1:0]    slot_id    [TABLE_SLOTS];
    logic [GRADE_W-1:0] slot_grade [TABLE_SLOTS];
    int                 table_fill;
    bit                 probe_sel;

    t_request req_backlog[$];
    t_rsp     pending_results[$];
    t_request cur_req;

    int  err_cnt;
    int  results_seen;
    bit  gaps_on;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    bit  hold_done;

    t_key key_pool [KEY_POOL];
    t_key fill_key [FILL_KEYS];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.day   = DAY_W'($urandom_range(0, 31));
        k.month = MONTH_W'($urandom_range(0, 15));
        k.year  = YEAR_W'($urandom_range(0, 16383));
        return k;
    endfunction

    function automatic t_rsp result_of(t_status st, int slot, logic [ID_W-1:0] id,
                                       logic [GRADE_W-1:0] gr, int cnt, bit last);
        t_rsp r;
        r.status = st;
        r.slot   = OSLOT_W'(slot);
        r.id     = id;
        r.grade  = gr;
        r.count  = OCNT_W'(cnt);
        r.last   = last;
        return r;
    endfunction

    // A match steps by one; a miss steps by the probe mode.
    function automatic int next_pos(input int pos, inout int qi, input bit after_hit);
        int n;
        if (after_hit || !probe_sel) return (pos + 1) % TABLE_SLOTS;
        n  = (pos + (qi * qi) % TABLE_SLOTS) % TABLE_SLOTS;
        qi = qi + 1;
        return n;
    endfunction

    task automatic apply_to_table(input t_request r);
        int pos;
        int qi;
        int probes;
        int hits;
        int emitted;
        int home_sum;
        bit hit;
        bit placed;
        home_sum = int'(r.key.day) * 5 + int'(r.key.month) * 4 + int'(r.key.year) / 48;
        pos      = (home_sum / 7) % TABLE_SLOTS;
        qi       = 0;
        hits     = 0;
        emitted  = 0;
        placed   = 1'b0;
        case (r.mode)
            MODE_IGNORE: ;
            MODE_INSERT: begin
                if (table_fill < TABLE_SLOTS) begin
                    for (probes = 0; probes < TABLE_SLOTS && !placed; probes++) begin
                        if (!slot_used[pos]) begin
                            slot_used[pos]  = 1'b1;
                            slot_key[pos]   = r.key;
                            slot_id[pos]    = r.id;
                            slot_grade[pos] = r.grade;
                            table_fill++;
                            placed = 1'b1;
                            pending_results.push_back(
                                result_of(STAT_INSERTED, pos, '0, '0, 0, 1'b1));
                        end else begin
                            pos = next_pos(pos, qi, 1'b0);
                        end
                    end
                end
                if (!placed)
                    pending_results.push_back(result_of(STAT_FULL, 0, '0, '0, 0, 1'b1));
            end
            default: begin
                // An exhausted run ends as if it had reached an empty slot.
                for (probes = 0; probes < TABLE_SLOTS; probes++) begin
                    if (!slot_used[pos]) break;
                    hit = (slot_key[pos] == r.key);
                    if (hit) begin
                        hits++;
                        if (r.mode == MODE_FIND) begin
                            if (emitted < MAX_MATCHES) begin
                                pending_results.push_back(result_of(STAT_MATCH, pos,
                                    slot_id[pos], slot_grade[pos], hits, 1'b0));
                                emitted++;
                            end
                        end else begin
                            slot_used[pos] = 1'b0;
                            if (table_fill > 0) table_fill--;
                        end
                    end
                    pos = next_pos(pos, qi, hit);
                end
                pending_results.push_back(result_of(
                    (r.mode == MODE_FIND) ? STAT_END : STAT_REMOVED, 0, '0, '0, hits, 1'b1));
            end
        endcase
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                apply_to_table(cur_req);
                send_gap = pick_gap();
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.mode        <= cur_req.mode;
                    req_if.birth_day   <= cur_req.key.day;
                    req_if.birth_month <= cur_req.key.month;
                    req_if.birth_year  <= cur_req.key.year;
                    req_if.student_id  <= cur_req.id;
                    req_if.grade       <= cur_req.grade;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result ready: random stalls plus one long hold to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left == 0) begin
                rsp_if.ready <= 1'b1;
            end else begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got.status = t_status'(rsp_if.status);
            got.slot   = rsp_if.slot;
            got.id     = rsp_if.found_id;
            got.grade  = rsp_if.found_grade;
            got.count  = rsp_if.match_count;
            got.last   = rsp_if.last;
            if (pending_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result: st=%0d slot=%0d id=%h gr=%h cnt=%0d last=%0d",
                             got.status, got.slot, got.id, got.grade, got.count, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"result mismatch: exp st=%0d slot=%0d id=%h gr=%h cnt=%0d ",
                                  "last=%0d, got st=%0d slot=%0d id=%h gr=%h cnt=%0d last=%0d"},
                                 want.status, want.slot, want.id, want.grade, want.count,
                                 want.last, got.status, got.slot, got.id, got.grade,
                                 got.count, got.last);
                end
            end
        end
    end

    task automatic push_req(t_mode mode, t_key key, logic [ID_W-1:0] id,
                            logic [GRADE_W-1:0] grade);
        t_request r;
        r.mode  = mode;
        r.key   = key;
        r.id    = id;
        r.grade = grade;
        req_backlog.push_back(r);
    endtask

    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_if.valid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_probe_mode(bit value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        probe_sel = value;
        @(negedge i_clk);
    endtask

    task automatic push_random(int count);
        int   r;
        t_mode mode;
        t_key key;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            mode = (r < 45) ? MODE_INSERT : (r < 75) ? MODE_FIND :
                   (r < 95) ? MODE_REMOVE : MODE_IGNORE;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                               : random_key();
            push_req(mode, key, ID_W'($urandom()), GRADE_W'($urandom()));
        end
    endtask

    initial begin
        t_key k_zero;
        t_key k_next;
        t_key k_max;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode  = MODE_INSERT;
        req_if.birth_day   = '0;
        req_if.birth_month = '0;
        req_if.birth_year  = '0;
        req_if.student_id  = '0;
        req_if.grade       = '0;
        rsp_if.ready = 1'b0;
        err_cnt      = 0;
        results_seen = 0;
        table_fill   = 0;
        probe_sel    = 1'b0;
        gaps_on      = 1'b1;
        foreach (key_pool[i]) key_pool[i] = random_key();
        foreach (fill_key[i]) fill_key[i] = random_key();
        k_zero = '{day: '0, month: '0, year: '0};
        k_next = '{day: DAY_W'(1), month: '0, year: '0};
        k_max  = '{day: '1, month: '1, year: '1};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table, duplicates, ignored kind, then a hole that hides a
        // record stored past its home slot.
        push_req(MODE_FIND,   k_zero, '0, '0);
        push_req(MODE_REMOVE, k_zero, '0, '0);
        push_req(MODE_INSERT, k_max,  '1, '1);
        push_req(MODE_INSERT, k_max,  '0, '0);
        push_req(MODE_IGNORE, k_max,  '1, '1);
        push_req(MODE_FIND,   k_max,  '0, '0);
        push_req(MODE_REMOVE, k_max,  '0, '0);
        push_req(MODE_FIND,   k_max,  '0, '0);
        push_req(MODE_INSERT, k_zero, 31'h2AAA_AAAA, 31'h5555_5555);
        push_req(MODE_INSERT, k_next, 31'h5555_5555, 31'h2AAA_AAAA);
        push_req(MODE_FIND,   k_next, '0, '0);
        push_req(MODE_REMOVE, k_zero, '0, '0);
        push_req(MODE_FIND,   k_next, '0, '0);
        push_req(MODE_INSERT, k_next, 31'h0123_4567, 31'h7654_3210);
        push_req(MODE_FIND,   k_next, '0, '0);
        push_req(MODE_REMOVE, k_next, '0, '0);
        push_req(MODE_FIND,   k_next, '0, '0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_probe_mode((ph % 2) == 0);
            gaps_on = (ph != 2);
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        // Pile many records under one key so a search finds more matches
        // than it reports, then search across the crowded region
        gaps_on = 1'b1;
        write_probe_mode(1'b0);
        for (int i = 0; i < FILL_ITEMS; i++)
            push_req(MODE_INSERT, fill_key[(i < DUP_ITEMS) ? 0 : i % FILL_KEYS],
                     ID_W'($urandom()), GRADE_W'($urandom()));
        foreach (fill_key[i]) push_req(MODE_FIND, fill_key[i], '0, '0);
        push_req(MODE_FIND, k_max, '0, '0);
        wait_drained();

        write_probe_mode(1'b1);
        push_req(MODE_INSERT, k_zero, '1, '0);
        push_req(MODE_FIND, fill_key[0], '0, '0);
        foreach (fill_key[i]) push_req(MODE_REMOVE, fill_key[i], '0, '0);
        push_random(12);
        wait_drained();

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/oaht_pkg.sv
sv/oaht_req_if.sv
sv/oaht_rsp_if.sv
sv/oaht_home.sv
sv/open_addressing_hash_table.sv
verif/open_addressing_hash_table_tb.sv
